/* sv/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;

  // Byte prefix masks and patterns
  localparam logic [7:0] MASK_LEAD2 = 8'he0;
  localparam logic [7:0] PAT_LEAD2  = 8'hc0;
  localparam logic [7:0] MASK_LEAD3 = 8'hf0;
  localparam logic [7:0] PAT_LEAD3  = 8'he0;
  localparam logic [7:0] MASK_LEAD4 = 8'hf8;
  localparam logic [7:0] PAT_LEAD4  = 8'hf0;
  localparam logic [7:0] MASK_CONT  = 8'hc0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_PAYLD = 8'h3f;

  localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

  // Everything one input byte causes: err_count error results, then an
  // optional tail result that closes the run.
  typedef struct packed {
    logic [1:0]       err_count;
    logic             has_tail;
    logic [CP_W-1:0]  tail_cp;
    logic             tail_bad;
    logic [CNT_W-1:0] tail_cnt;
  } run_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/u8d_in_if.sv */
// ----------------------------------------------------------------------------
// u8d_in_if
// Byte channel: one text byte and its end-of-text mark per beat.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

/* sv/u8d_out_if.sv */
// ----------------------------------------------------------------------------
// u8d_out_if
// Result channel: one decoded code point or error per beat.
// ----------------------------------------------------------------------------
interface u8d_out_if;
  logic                           valid;
  logic                           ready;
  logic [u8d_pkg::CP_W-1:0]       code_point;
  logic                           bad_sequence;
  logic [u8d_pkg::CNT_W-1:0]      bytes_consumed;
  logic                           last_of_run;

  modport source (output valid, code_point, bad_sequence, bytes_consumed, last_of_run,
                  input ready);
  modport sink   (input valid, code_point, bad_sequence, bytes_consumed, last_of_run,
                  output ready);
endinterface

/* sv/u8d_front.sv */
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, tracks the open sequence and emits one run descriptor per
// byte that produces results.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic            clk,
  input  logic            rst,
  u8d_in_if.sink          text,
  input  u8d_pkg::q_stat_t q_stat,
  output logic            push,
  output u8d_pkg::run_t   run
);

  logic [2:0]                 exp_len, exp_len_next;
  logic [1:0]                 taken, taken_next;
  logic [u8d_pkg::CP_W-1:0]   partial, partial_next;

  logic [7:0]                 b;
  logic                       eot;
  logic                       accept;
  logic                       is_cont;
  logic [2:0]                 lead_len;
  logic [u8d_pkg::CP_W-1:0]   lead_val;
  logic                       lead_tail;
  logic                       lead_bad;
  logic [1:0]                 taken_inc;
  logic [u8d_pkg::CP_W-1:0]   cont_val;
  logic                       seq_done;

  assign text.ready = !q_stat.full;
  assign accept     = text.valid && text.ready;
  assign b          = text.text_byte;
  assign eot        = text.end_of_text;
  assign is_cont    = (b & u8d_pkg::MASK_CONT) == u8d_pkg::PAT_CONT;

  // Lead classification; LEN_NONE marks an invalid lead
  always_comb begin
    lead_len = u8d_pkg::LEN_NONE;
    lead_val = '0;
    priority if (!b[7]) begin
      lead_len = u8d_pkg::LEN_1;
      lead_val = {13'd0, b};
    end else if ((b & u8d_pkg::MASK_LEAD2) == u8d_pkg::PAT_LEAD2) begin
      lead_len = u8d_pkg::LEN_2;
      lead_val = {16'd0, b[4:0]};
    end else if ((b & u8d_pkg::MASK_LEAD3) == u8d_pkg::PAT_LEAD3) begin
      lead_len = u8d_pkg::LEN_3;
      lead_val = {17'd0, b[3:0]};
    end else if ((b & u8d_pkg::MASK_LEAD4) == u8d_pkg::PAT_LEAD4) begin
      lead_len = u8d_pkg::LEN_4;
      lead_val = {18'd0, b[2:0]};
    end else begin
      lead_len = u8d_pkg::LEN_NONE;
    end
  end

  // A lead gives a result unless it opens a multi-byte sequence
  assign lead_tail = (lead_len == u8d_pkg::LEN_1) || (lead_len == u8d_pkg::LEN_NONE) || eot;
  assign lead_bad  = (lead_len != u8d_pkg::LEN_1);

  assign taken_inc = taken + 2'd1;
  assign cont_val  = {partial[u8d_pkg::CP_W-7:0], b[5:0]};
  assign seq_done  = ({1'b0, taken_inc} + 3'd1) >= exp_len;

  always_comb begin
    exp_len_next = exp_len;
    taken_next   = taken;
    partial_next = partial;
    push         = 1'b0;
    run          = '0;
    if (accept) begin
      if (exp_len != u8d_pkg::LEN_NONE && is_cont) begin
        if (seq_done) begin
          push         = 1'b1;
          run.has_tail = 1'b1;
          run.tail_cp  = cont_val;
          run.tail_cnt = exp_len;
          exp_len_next = u8d_pkg::LEN_NONE;
          taken_next   = '0;
          partial_next = '0;
        end else if (eot) begin
          // truncated: lead plus every continuation taken, this one too
          push          = 1'b1;
          run.err_count = taken_inc;
          run.has_tail  = 1'b1;
          run.tail_bad  = 1'b1;
          run.tail_cnt  = u8d_pkg::LEN_1;
          exp_len_next  = u8d_pkg::LEN_NONE;
          taken_next    = '0;
          partial_next  = '0;
        end else begin
          taken_next   = taken_inc;
          partial_next = cont_val;
        end
      end else begin
        if (exp_len != u8d_pkg::LEN_NONE) begin
          // broken sequence: flush errors, then decode this byte as a lead
          run.err_count = taken + 2'd1;
        end
        run.has_tail = lead_tail;
        run.tail_bad = lead_bad;
        run.tail_cp  = lead_bad ? '0 : lead_val;
        run.tail_cnt = u8d_pkg::LEN_1;
        push         = lead_tail || (exp_len != u8d_pkg::LEN_NONE);
        if (lead_tail) begin
          exp_len_next = u8d_pkg::LEN_NONE;
          taken_next   = '0;
          partial_next = '0;
        end else begin
          exp_len_next = lead_len;
          taken_next   = '0;
          partial_next = lead_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= u8d_pkg::LEN_NONE;
      taken   <= '0;
      partial <= '0;
    end else begin
      exp_len <= exp_len_next;
      taken   <= taken_next;
      partial <= partial_next;
    end
  end

endmodule

/* sv/u8d_queue.sv */
// ----------------------------------------------------------------------------
// u8d_queue
// Small FIFO of run descriptors between the front and the back.
// ----------------------------------------------------------------------------
module u8d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  u8d_pkg::q_ctrl_t  ctrl,
  input  u8d_pkg::run_t     wr_run,
  output u8d_pkg::run_t     head,
  output u8d_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u8d_pkg::run_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/u8d_back.sv */
// ----------------------------------------------------------------------------
// u8d_back
// Expands the head run descriptor into result beats through an output
// register, one beat per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic              clk,
  input  logic              rst,
  input  u8d_pkg::run_t     head,
  input  u8d_pkg::q_stat_t  q_stat,
  output logic              pop,
  u8d_out_if.source         result
);

  logic [1:0]                 err_idx, err_idx_next;
  logic                       load;
  logic                       in_errs;
  logic                       gen_last;
  logic [u8d_pkg::CP_W-1:0]   gen_cp;
  logic                       gen_bad;
  logic [u8d_pkg::CNT_W-1:0]  gen_cnt;

  assign in_errs = err_idx < head.err_count;

  always_comb begin
    if (in_errs) begin
      gen_cp   = '0;
      gen_bad  = 1'b1;
      gen_cnt  = u8d_pkg::LEN_1;
      gen_last = ((err_idx + 2'd1) == head.err_count) && !head.has_tail;
    end else begin
      gen_cp   = head.tail_cp;
      gen_bad  = head.tail_bad;
      gen_cnt  = head.tail_cnt;
      gen_last = 1'b1;
    end
  end

  assign load = !q_stat.empty && (!result.valid || result.ready);
  assign pop  = load && gen_last;

  always_comb begin
    err_idx_next = err_idx;
    if (pop) begin
      err_idx_next = '0;
    end else if (load) begin
      err_idx_next = err_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_idx      <= '0;
      result.valid <= 1'b0;
    end else begin
      err_idx <= err_idx_next;
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.code_point     <= gen_cp;
      result.bad_sequence   <= gen_bad;
      result.bytes_consumed <= gen_cnt;
      result.last_of_run    <= gen_last;
    end
  end

endmodule

/* sv/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with per-byte error reporting.
// ----------------------------------------------------------------------------
// Throughput: one byte accepted per cycle while the run queue has room.
// The first result of a byte passes through the run queue, then the output register.
// A byte that causes k results (up to 4) gives them out of the output register one by one.
// Reset (rst, synchronous) closes any open sequence and empties queue and output.
module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  u8d_in_if.sink     text,
  u8d_out_if.source  result
);

  u8d_pkg::q_ctrl_t q_ctrl;
  u8d_pkg::q_stat_t q_stat;
  u8d_pkg::run_t    wr_run;
  u8d_pkg::run_t    head;
  logic             push;
  logic             pop;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  u8d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_stat (q_stat),
    .push   (push),
    .run    (wr_run)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .wr_run (wr_run),
    .head   (head),
    .stat   (q_stat)
  );

  u8d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

endmodule

/* bench/utf8_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the UTF-8 stream decoder. A driver pushes text bytes
// from a queue and decodes each accepted beat in a local copy of the decoder
// state. A monitor compares every result beat against the oldest predicted
// code point or error. Stimulus is a directed set of corner cases followed by
// random text that is mostly well-formed, with truncated and broken sequences
// mixed in, under three sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic [u8d_pkg::CP_W-1:0]  cp;
    logic                      bad;
    logic [u8d_pkg::CNT_W-1:0] cnt;
    logic                      last;
  } decoded_t;

  logic clk;
  logic rst;

  u8d_in_if  text_ch ();
  u8d_out_if result_ch ();

  utf8_stream_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  text_beat_t text_bytes[$];
  decoded_t   pending_points[$];
  decoded_t   run_points[$];

  // decoder state mirror
  logic [u8d_pkg::CNT_W-1:0] open_len;
  logic [1:0]                taken;
  logic [u8d_pkg::CP_W-1:0]  acc;

  int send_idle_pct;
  int recv_idle_pct;
  logic hold_start;
  int hold_left;
  int cycle_count;
  int mismatches;
  int bytes_accepted;
  int results_seen;
  int bad_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------
  task automatic note_result(input logic [u8d_pkg::CP_W-1:0] cp, input logic bad,
                             input logic [u8d_pkg::CNT_W-1:0] cnt);
    decoded_t r;
    r.cp   = bad ? '0 : cp;
    r.bad  = bad;
    r.cnt  = cnt;
    r.last = 1'b0;
    run_points.push_back(r);
  endtask

  // one error for the lead plus one per continuation taken, then close
  task automatic flush_open();
    for (int k = 0; k < 1 + int'(taken); k++) note_result('0, 1'b1, u8d_pkg::LEN_1);
    open_len = u8d_pkg::LEN_NONE;
    taken    = '0;
    acc      = '0;
  endtask

  task automatic open_lead(input logic [7:0] b, input logic eot);
    logic [u8d_pkg::CNT_W-1:0] len;
    logic [7:0]                keep;
    len  = u8d_pkg::LEN_NONE;
    keep = '0;
    if (b < u8d_pkg::PAT_CONT) begin
      note_result(u8d_pkg::CP_W'(b), 1'b0, u8d_pkg::LEN_1);
    end else begin
      if ((b & u8d_pkg::MASK_LEAD2) == u8d_pkg::PAT_LEAD2) begin
        len  = u8d_pkg::LEN_2;
        keep = ~u8d_pkg::MASK_LEAD2;
      end else if ((b & u8d_pkg::MASK_LEAD3) == u8d_pkg::PAT_LEAD3) begin
        len  = u8d_pkg::LEN_3;
        keep = ~u8d_pkg::MASK_LEAD3;
      end else if ((b & u8d_pkg::MASK_LEAD4) == u8d_pkg::PAT_LEAD4) begin
        len  = u8d_pkg::LEN_4;
        keep = ~u8d_pkg::MASK_LEAD4;
      end
      if (len == u8d_pkg::LEN_NONE || eot) begin
        note_result('0, 1'b1, u8d_pkg::LEN_1);
      end else begin
        open_len = len;
        taken    = '0;
        acc      = u8d_pkg::CP_W'(b & keep);
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    run_points.delete();
    if (open_len != u8d_pkg::LEN_NONE) begin
      if ((b & u8d_pkg::MASK_CONT) == u8d_pkg::PAT_CONT) begin
        acc   = (acc << 6) | u8d_pkg::CP_W'(b & u8d_pkg::MASK_PAYLD);
        taken = taken + 2'd1;
        if (int'(taken) + 1 >= int'(open_len)) begin
          note_result(acc, 1'b0, open_len);
          open_len = u8d_pkg::LEN_NONE;
          taken    = '0;
          acc      = '0;
        end else if (eot) begin
          flush_open();
        end
      end else begin
        flush_open();
        open_lead(b, eot);
      end
    end else begin
      open_lead(b, eot);
    end
    if (run_points.size() > 0) run_points[run_points.size() - 1].last = 1'b1;
    foreach (run_points[i]) pending_points.push_back(run_points[i]);
  endtask

  // ------------------------------------------------------------------
  // Driver
  // ------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    text_beat_t nxt;
    if (rst) begin
      text_ch.valid <= 1'b0;
      open_len = u8d_pkg::LEN_NONE;
      taken    = '0;
      acc      = '0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        decode_byte(text_ch.text_byte, text_ch.end_of_text);
        bytes_accepted++;
      end
      if (!text_ch.valid || text_ch.ready) begin
        if (text_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = text_bytes.pop_front();
          text_ch.valid       <= 1'b1;
          text_ch.text_byte   <= nxt.b;
          text_ch.end_of_text <= nxt.eot;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor
  // ------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_monitor
    decoded_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (result_ch.bad_sequence) bad_seen++;
        if (pending_points.size() == 0) begin
          log_mismatch($sformatf("unexpected beat cp=%h bad=%b cnt=%0d last=%b",
                                 result_ch.code_point, result_ch.bad_sequence,
                                 result_ch.bytes_consumed, result_ch.last_of_run));
        end else begin
          want = pending_points.pop_front();
          if (result_ch.code_point !== want.cp || result_ch.bad_sequence !== want.bad ||
              result_ch.bytes_consumed !== want.cnt || result_ch.last_of_run !== want.last)
            log_mismatch($sformatf("got %h/%b/%0d/%b want %h/%b/%0d/%b",
                                   result_ch.code_point, result_ch.bad_sequence,
                                   result_ch.bytes_consumed, result_ch.last_of_run,
                                   want.cp, want.bad, want.cnt, want.last));
        end
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= LONG_HOLD;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("utf8_stream_decoder_tb: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  task automatic push_beat(input logic [7:0] b, input logic eot);
    text_beat_t t;
    t.b   = b;
    t.eot = eot;
    text_bytes.push_back(t);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      1: return {1'b0, 7'($urandom_range(127))};
      2: return {3'b110, 5'($urandom_range(31))};
      3: return {4'b1110, 4'($urandom_range(15))};
      default: return {5'b11110, 3'($urandom_range(7))};
    endcase
  endfunction

  // mostly well-formed characters; the rest truncated, invalid or raw noise
  task automatic queue_random_text(input int n_bytes);
    logic [7:0] unit[$];
    int pushed;
    int kind;
    int len;
    logic eot;
    pushed = 0;
    while (pushed < n_bytes) begin
      unit.delete();
      kind = $urandom_range(99);
      eot  = ($urandom_range(9) == 0);
      if (kind < 65) begin
        len = $urandom_range(4, 1);
        unit.push_back(lead_byte(len));
        for (int k = 1; k < len; k++) unit.push_back(cont_byte());
      end else if (kind < 80) begin
        len = $urandom_range(4, 2);
        unit.push_back(lead_byte(len));
        for (int k = $urandom_range(len - 2, 0); k > 0; k--) unit.push_back(cont_byte());
      end else if (kind < 90) begin
        unit.push_back($urandom_range(1) ? cont_byte() : {5'b11111, 3'($urandom_range(7))});
      end else begin
        unit.push_back(8'($urandom_range(255)));
      end
      foreach (unit[i]) push_beat(unit[i], eot && (i == unit.size() - 1));
      pushed += unit.size();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (text_bytes.size() != 0 || text_ch.valid || pending_points.size() != 0);
  endtask

  initial begin
    rst                  = 1'b1;
    text_ch.valid        = 1'b0;
    text_ch.text_byte    = '0;
    text_ch.end_of_text  = 1'b0;
    result_ch.ready      = 1'b0;
    hold_start           = 1'b0;
    send_idle_pct        = 34;
    recv_idle_pct        = 70;
    cycle_count          = 0;
    mismatches           = 0;
    bytes_accepted       = 0;
    results_seen         = 0;
    bad_seen             = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    push_beat(8'h00, 1'b0);
    push_beat(8'h7f, 1'b1);
    push_beat(8'hdf, 1'b0); push_beat(8'hbf, 1'b0);
    push_beat(8'hef, 1'b0); push_beat(8'hbf, 1'b0); push_beat(8'hbf, 1'b0);
    // largest 21-bit value
    push_beat(8'hf7, 1'b0); push_beat(8'hbf, 1'b0); push_beat(8'hbf, 1'b0);
    push_beat(8'hbf, 1'b0);
    // invalid leads
    push_beat(8'h80, 1'b0);
    push_beat(8'hff, 1'b0);
    // bad continuation after two good ones: three errors then 'A'
    push_beat(8'hf0, 1'b0); push_beat(8'h80, 1'b0); push_beat(8'h80, 1'b0);
    push_beat(8'h41, 1'b0);
    // bad continuation that is itself an invalid lead
    push_beat(8'hc2, 1'b0); push_beat(8'hff, 1'b0);
    // lead cut off by end of text
    push_beat(8'he0, 1'b1);
    // continuation cut off by end of text
    push_beat(8'hf0, 1'b0); push_beat(8'h90, 1'b0); push_beat(8'h80, 1'b1);
    // breaking byte opens a new sequence
    push_beat(8'he1, 1'b0); push_beat(8'hc3, 1'b0); push_beat(8'ha9, 1'b1);
    wait_drained();

    // random text; receiver stalls long enough to back up the input
    queue_random_text(25);
    repeat (10) @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_drained();

    send_idle_pct = 70;
    recv_idle_pct = 34;
    queue_random_text(25);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_text(25);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("run covered %0d text bytes and %0d result beats, %0d of them errors",
             bytes_accepted, results_seen, bad_seen);
    $display("idling mixes: sender-heavy, receiver-heavy, none; one long receiver stall");
    if (mismatches == 0) begin
      $display("utf8_stream_decoder_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("utf8_stream_decoder_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/u8d_pkg.sv
sv/u8d_in_if.sv
sv/u8d_out_if.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
